// File: sv/rbe_pkg.sv
package rbe_pkg;

    // Width of the run and literal counters; it holds any block size up to 127.
    localparam int CNT_W = 7;

    // A literal block header is the literal count plus this offset.
    localparam logic [7:0] LIT_HEADER = 8'h80;

    // A run count byte carries the low seven bits of the run length.
    localparam logic [7:0] RUN_MASK = 8'h7F;

    // Input commands.
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // One input item.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } t_out;

    // What one accepted item has to emit, in order: error, run, literal block.
    typedef struct packed {
        logic             err;
        logic             run_en;
        logic [CNT_W-1:0] run_len;
        logic [7:0]       run_byte;
        logic [CNT_W-1:0] lit_cnt;
    } t_plan;

    // Write into the literal store.
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } t_wr;

endpackage

// File: sv/rbe_emit.sv
module rbe_emit #(
    parameter int MAX_BLOCK = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rbe_pkg::t_plan i_plan,
    input  rbe_pkg::t_wr  i_wr,
    output logic          o_busy,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rbe_pkg::t_out o_out
);
    import rbe_pkg::*;

    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_ERR      = 6'b000010,
        S_RUN_CNT  = 6'b000100,
        S_RUN_VAL  = 6'b001000,
        S_LIT_HDR  = 6'b010000,
        S_LIT_DATA = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_run_len, n_run_len;
    logic [7:0]       r_run_byte, n_run_byte;
    logic [CNT_W-1:0] r_lit_cnt, n_lit_cnt;
    logic [AW-1:0]    r_idx, n_idx;
    logic [7:0]       r_rd_data;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    logic [7:0]       mem [MAX_BLOCK];
    logic             w_out_free;
    logic             w_lit_end;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_lit_end  = (CNT_W'(r_idx) + CNT_W'(1)) == r_lit_cnt;

    // Sequencer: one result byte is loaded whenever the output register is free.
    always_comb begin
        n_state     = r_state;
        n_run_len   = r_run_len;
        n_run_byte  = r_run_byte;
        n_lit_cnt   = r_lit_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_run_len  = i_plan.run_len;
                    n_run_byte = i_plan.run_byte;
                    n_lit_cnt  = i_plan.lit_cnt;
                    n_idx      = '0;
                    priority if (i_plan.err) begin
                        n_state = S_ERR;
                    end else if (i_plan.run_en) begin
                        n_state = S_RUN_CNT;
                    end else begin
                        n_state = S_LIT_HDR;
                    end
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: 8'h00, last: 1'b1, error: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_RUN_CNT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: 8'(r_run_len) & RUN_MASK, last: 1'b0,
                                    error: 1'b0};
                    n_state     = S_RUN_VAL;
                end
            end
            S_RUN_VAL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: r_run_byte, last: (r_lit_cnt == '0),
                                    error: 1'b0};
                    n_state     = (r_lit_cnt == '0) ? S_IDLE : S_LIT_HDR;
                end
            end
            S_LIT_HDR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: 8'(r_lit_cnt) + LIT_HEADER, last: 1'b0,
                                    error: 1'b0};
                    n_state     = S_LIT_DATA;
                end
            end
            S_LIT_DATA: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_byte: r_rd_data, last: w_lit_end, error: 1'b0};
                    if (w_lit_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_run_len  <= n_run_len;
        r_run_byte <= n_run_byte;
        r_lit_cnt  <= n_lit_cnt;
        r_out      <= n_out;
    end

    // Literal store. The read address is the next index, so the registered
    // read data always holds the entry at the current index.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= mem[n_idx];
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: sv/rle_byte_encoder_unit.sv
// Run-length byte encoder in the PackBits style.
// Input channel i_in: one item per byte (cmd 0) or an end of stream (cmd 1).
// Output channel o_out: one encoded byte per item, with last on the final
// byte that an input item causes and error on the reply to an empty end.
// Both channels use valid and ready; an item moves when both are high.
// An input item that causes no result is simply accepted, and the next item
// may follow at once. An item that causes results drops o_in_ready while
// they are produced: the accept moves the sequencer out of idle, which
// then loads the first result into the output register and one result per
// cycle after it while the receiver takes them. Literal bytes come from a
// memory whose read address runs one step ahead, which sets that rate.
// A stalled receiver holds the output register and the sequencer waits;
// a new input item is accepted while the last result still waits to be taken.
// Reset (synchronous, active low) clears the run and literal state, the
// sequencer and the output valid flag; the literal store needs no
// clearing: an entry is read only once written in the same literal block.
module rle_byte_encoder_unit #(
    parameter int MAX_BLOCK = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rbe_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rbe_pkg::t_out o_out
);
    import rbe_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

    logic [7:0]       r_cur, n_cur;
    logic [CNT_W-1:0] r_run, n_run;
    logic [CNT_W-1:0] r_lit, n_lit;
    logic             r_have, n_have;

    logic             w_accept;
    logic             w_busy;
    logic             w_start;
    logic [CNT_W-1:0] w_lit_inc;
    t_plan            w_plan;
    t_wr              w_wr;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_lit_inc = r_lit + CNT_W'(1);

    // Per-item update of the run state, and the plan of what to emit.
    always_comb begin
        n_cur  = r_cur;
        n_run  = r_run;
        n_lit  = r_lit;
        n_have = r_have;
        w_plan = '0;
        w_wr   = '0;
        if (w_accept) begin
            if (i_in.cmd == CMD_DATA) begin
                priority if (!r_have) begin
                    n_cur  = i_in.data_byte;
                    n_run  = CNT_W'(1);
                    n_have = 1'b1;
                end else if (i_in.data_byte == r_cur && r_run < MAX_CNT) begin
                    n_run          = r_run + CNT_W'(1);
                    w_plan.lit_cnt = r_lit;
                    n_lit          = '0;
                end else if (r_run == CNT_W'(1)) begin
                    w_wr  = '{en: 1'b1, addr: r_lit, data: r_cur};
                    n_cur = i_in.data_byte;
                    if (w_lit_inc >= MAX_CNT) begin
                        w_plan.lit_cnt = w_lit_inc;
                        n_lit          = '0;
                    end else begin
                        n_lit = w_lit_inc;
                    end
                end else begin
                    w_plan.run_en   = 1'b1;
                    w_plan.run_len  = r_run;
                    w_plan.run_byte = r_cur;
                    n_cur           = i_in.data_byte;
                    n_run           = CNT_W'(1);
                end
            end else begin
                priority if (!r_have) begin
                    w_plan.err = 1'b1;
                end else if (r_run == CNT_W'(1)) begin
                    w_wr           = '{en: 1'b1, addr: r_lit, data: r_cur};
                    w_plan.lit_cnt = w_lit_inc;
                end else begin
                    w_plan.run_en   = 1'b1;
                    w_plan.run_len  = r_run;
                    w_plan.run_byte = r_cur;
                    w_plan.lit_cnt  = r_lit;
                end
                n_cur  = '0;
                n_run  = CNT_W'(1);
                n_lit  = '0;
                n_have = 1'b0;
            end
        end
    end

    assign w_start = w_accept && (w_plan.err || w_plan.run_en || (w_plan.lit_cnt != '0));

    // Run and literal state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_run  <= CNT_W'(1);
            r_lit  <= '0;
            r_have <= 1'b0;
        end else begin
            r_cur  <= n_cur;
            r_run  <= n_run;
            r_lit  <= n_lit;
            r_have <= n_have;
        end
    end

    // Literal store, result sequencer and output register.
    rbe_emit #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_plan      (w_plan),
        .i_wr        (w_wr),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    assign o_in_ready = !w_busy;

`ifndef SYNTH
    // With no pending byte the run and literal state are at their reset values.
    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_run == CNT_W'(1)) && (r_lit == '0))
        else $error("run state not cleared while no byte is pending");

    // The literal block never reaches the block size without being flushed.
    a_lit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lit < MAX_CNT)
        else $error("literal block holds the block size or more");

    // An end of stream always produces results, so input stalls next cycle.
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.cmd == CMD_END)) |=> !o_in_ready)
        else $error("end of stream accepted without results");

    // An error result is always the final result of its item.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.error) |-> o_out.last)
        else $error("error result without last");
`endif

endmodule

// File: tb/sv/tb_rle_byte_encoder_unit.sv
module tb_rle_byte_encoder_unit;

    import rbe_pkg::*;

    localparam int BLOCK_MAX = 63;
    localparam int RANDOM_ITEMS = 145;
    localparam int CYCLE_LIMIT = 600000;
    localparam int REPORT_MAX = 10;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_item;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_item;

    rle_byte_encoder_unit #(
        .MAX_BLOCK(BLOCK_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item)
    );

    // Encoder state mirror and queue of the bytes still to come out.
    class rle_scoreboard;
        t_out             code_q[$];
        t_out             step_q[$];
        logic [7:0]       run_byte;
        logic [CNT_W-1:0] run_len;
        logic [CNT_W-1:0] lit_cnt;
        logic [7:0]       lit_mem[BLOCK_MAX];
        bit               in_stream;
        int               failures;
        int               bytes_checked;
        int               empty_ends;
        int               long_flushes;

        function new();
            failures = 0;
            bytes_checked = 0;
            empty_ends = 0;
            long_flushes = 0;
            clear_state();
        endfunction

        function void clear_state();
            run_byte = 8'h00;
            run_len = 1;
            lit_cnt = 0;
            in_stream = 0;
        endfunction

        function void push_byte(logic [7:0] b, logic err);
            t_out r;
            r.out_byte = b;
            r.last = 1'b0;
            r.error = err;
            step_q.insert(step_q.size(), r);
        endfunction

        function void flush_literals();
            if (lit_cnt == 0)
                return;
            if (lit_cnt == BLOCK_MAX)
                long_flushes++;
            push_byte({1'b0, lit_cnt} + LIT_HEADER, 1'b0);
            for (int i = 0; i < lit_cnt; i++)
                push_byte(lit_mem[i], 1'b0);
            lit_cnt = 0;
        endfunction

        function void add_literal(logic [7:0] b);
            if (lit_cnt < BLOCK_MAX) begin
                lit_mem[lit_cnt] = b;
                lit_cnt++;
            end
            if (lit_cnt >= BLOCK_MAX)
                flush_literals();
        endfunction

        function void emit_run();
            if (run_len == BLOCK_MAX)
                long_flushes++;
            push_byte({1'b0, run_len} & RUN_MASK, 1'b0);
            push_byte(run_byte, 1'b0);
        endfunction

        // Work out the encoded bytes that one accepted item causes.
        function void note_input(t_in item);
            t_out tail;
            step_q.delete();
            if (item.cmd == CMD_DATA) begin
                if (!in_stream) begin
                    run_byte = item.data_byte;
                    run_len = 1;
                    in_stream = 1;
                end else if (item.data_byte == run_byte && run_len < BLOCK_MAX) begin
                    run_len++;
                    flush_literals();
                end else if (run_len == 1) begin
                    add_literal(run_byte);
                    run_byte = item.data_byte;
                end else begin
                    emit_run();
                    run_byte = item.data_byte;
                    run_len = 1;
                end
            end else begin
                if (!in_stream) begin
                    push_byte(8'h00, 1'b1);
                    empty_ends++;
                end else begin
                    if (run_len == 1)
                        add_literal(run_byte);
                    else
                        emit_run();
                    flush_literals();
                end
                clear_state();
            end
            if (step_q.size() > 0) begin
                tail = step_q[step_q.size() - 1];
                tail.last = 1'b1;
                step_q[step_q.size() - 1] = tail;
            end
            foreach (step_q[i])
                code_q.insert(code_q.size(), step_q[i]);
        endfunction

        function void report(string what, t_out exp_r, t_out got_r);
            failures++;
            if (failures <= REPORT_MAX)
                $display("MISMATCH %s: expected %02h last %0b err %0b, got %02h last %0b err %0b",
                         what, exp_r.out_byte, exp_r.last, exp_r.error,
                         got_r.out_byte, got_r.last, got_r.error);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(t_out got_r);
            t_out exp_r;
            bytes_checked++;
            if (code_q.size() == 0) begin
                exp_r = '0;
                report("unexpected result", exp_r, got_r);
                return;
            end
            exp_r = code_q.pop_front();
            if (got_r.out_byte !== exp_r.out_byte)
                report("out_byte", exp_r, got_r);
            else if (got_r.last !== exp_r.last)
                report("last", exp_r, got_r);
            else if (got_r.error !== exp_r.error)
                report("error", exp_r, got_r);
        endfunction

        // Anything still queued at the end never arrived.
        function void check_leftovers();
            t_out none;
            none = '0;
            while (code_q.size() > 0)
                report("missing result", code_q.pop_front(), none);
        endfunction

        function int pending();
            return code_q.size();
        endfunction
    endclass

    rle_scoreboard sb;
    int            burst_left;
    int            items_sent;
    int            streams_sent;
    int            cycle_count = 0;
    int            ready_mode = 0;
    int            mode_left = 0;
    int            stall_left = 0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver back-pressure: one of four ready modes, each held for a random span.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
        end else begin
            mode_left = mode_left - 1;
        end
        case (ready_mode)
            0: begin
                out_ready <= 1'b1;
            end
            1: begin
                out_ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                out_ready <= $urandom_range(0, 1);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left = stall_left - 1;
                    out_ready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 2) == 0)
                        stall_left = $urandom_range(1, 8);
                    out_ready <= 1'b1;
                end
            end
        endcase
    end

    // Check every result that the receiver takes.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_result(out_item);
    end

    // Offer one item and hold it until accepted; bursts are separated by gaps.
    task automatic send_item(input logic cmd, input logic [7:0] b);
        t_in item;
        item.cmd = cmd;
        item.data_byte = b;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 60);
            else
                burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge i_clk); while (!in_ready);
        sb.note_input(item);
        items_sent++;
        if (cmd == CMD_END)
            streams_sent++;
        burst_left--;
        if (burst_left == 0)
            in_valid <= 1'b0;
    endtask

    // Drop valid unless the last accept already did.
    task automatic hold_input();
        if (burst_left != 0) begin
            in_valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    // Hold the sender until the encoder has drained.
    task automatic drain_output();
        hold_input();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_run(input logic [7:0] v, input int len);
        repeat (len) send_item(CMD_DATA, v);
    endtask

    // Bytes that each differ from the one before them.
    task automatic send_literals(input int len);
        logic [7:0] v;
        v = pick_byte();
        repeat (len) begin
            send_item(CMD_DATA, v);
            v = v + 8'($urandom_range(1, 255));
        end
    endtask

    // A well-formed stream: a few runs and literal stretches, then an end.
    task automatic send_stream();
        int segs;
        segs = $urandom_range(1, 4);
        repeat (segs) begin
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 24) == 0)
                    send_run(pick_byte(), $urandom_range(60, 70));
                else
                    send_run(pick_byte(), $urandom_range(2, 6));
            end else begin
                if ($urandom_range(0, 24) == 0)
                    send_literals($urandom_range(60, 66));
                else
                    send_literals($urandom_range(1, 8));
            end
        end
        send_item(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    // Short random sequences with ends at random places.
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 2) == 0)
                send_item(CMD_END, 8'($urandom_range(0, 255)));
            else
                send_item(CMD_DATA, pick_byte());
        end
    endtask

    initial begin
        int random_start;
        sb = new();
        burst_left = 0;
        items_sent = 0;
        streams_sent = 0;
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ends with no data, the second with a non-zero byte field.
        send_item(CMD_END, 8'h00);
        send_item(CMD_END, 8'hFF);
        // A single byte becomes a one-byte literal block.
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_END, 8'h00);
        // Shortest run.
        send_run(8'hFF, 2);
        send_item(CMD_END, 8'h00);
        // Literals pending when a run starts, then a run open at the end.
        send_item(CMD_DATA, 8'h12);
        send_item(CMD_DATA, 8'h34);
        send_run(8'h56, 3);
        send_item(CMD_END, 8'h5A);
        // Literal block open at the end.
        send_item(CMD_DATA, 8'hAA);
        send_item(CMD_DATA, 8'h55);
        send_item(CMD_DATA, 8'hA5);
        send_item(CMD_DATA, 8'h5A);
        send_item(CMD_END, 8'hFF);
        // A run closed by a different byte, which is then left alone.
        send_run(8'h80, 2);
        send_item(CMD_DATA, 8'h7F);
        send_item(CMD_END, 8'h00);
        drain_output();

        // A run past its limit and a literal block that fills up.
        random_start = items_sent;
        send_run(pick_byte(), BLOCK_MAX + 2);
        send_item(CMD_END, 8'($urandom_range(0, 255)));
        send_literals(BLOCK_MAX + 1);
        send_item(CMD_END, 8'($urandom_range(0, 255)));

        while (items_sent - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_stream();
            if ($urandom_range(0, 7) == 0)
                drain_output();
        end
        send_item(CMD_END, 8'($urandom_range(0, 255)));

        hold_input();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        sb.check_leftovers();

        $display("Covered %0d items in %0d streams, %0d encoded bytes, %0d empty ends,",
                 items_sent, streams_sent, sb.bytes_checked, sb.empty_ends);
        $display("and %0d full-size runs or literal blocks; %0d failures.",
                 sb.long_flushes, sb.failures);
        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
